@@ hw/rtl/hmh_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Shared widths, operation and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hmh_pkg;

	localparam int HEAP_DEPTH_DEF   = 1024;
	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int WEIGHT_BITS_DEF  = 32;

	localparam int OP_W     = 2;
	localparam int VERTEX_W = 10;
	localparam int WEIGHT_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_DECREASE = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// Source of the heap memory read address.
	typedef enum logic [2:0] {
		HR_ROOT   = 3'd0,
		HR_POS    = 3'd1,
		HR_LAST   = 3'd2,
		HR_PARENT = 3'd3,
		HR_LEFT   = 3'd4,
		HR_RIGHT  = 3'd5
	} hsel_t;

	typedef struct packed {
		logic    ld_in;
		logic    clr_wr;
		hsel_t   hsel;
		logic    ins_start;
		logic    dec_start;
		logic    root_cap;
		logic    last_cap;
		logic    left_cap;
		logic    up_move;
		logic    dn_move;
		logic    place;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic clr_done;
		logic in_range;
		logic full;
		logic pos_valid;
		logic dec_ok;
		logic weight_lower;
		logic count_zero;
		logic last_zero;
		logic idx_zero;
		logic up_swap;
		logic has_left;
		logic dn_swap;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/indexed_min_heap_core.sv @@
// ----------------------------------------------------------------------------
// Indexed binary min-heap with decrease-key
// Holds (vertex, weight) entries with a per-vertex position map and performs
// insert, extract-minimum and decrease-key, one operation at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Carries
//  s_*       in         s_tvalid / s_tready    one operation
//  m_*       out        m_tvalid / m_tready    one result per operation
//  cfg_*     in         cfg_valid / cfg_ready  capacity limit write
//
// Each sift level is a registered read of the heap memory followed by a
// compare and write, through S_UP_TEST and S_UP_CMP going up and through
// S_DN_TEST, S_DN_LEFT and S_DN_CMP going down, as both children are read
// through the single read port.
// After reset the position map is cleared one entry a cycle, so no
// transaction is accepted until that pass ends; configuration is taken.
// A stalled result waits in the output register; the next operation is
// accepted meanwhile, and its result waits until that register is free.
//
`default_nettype none

module indexed_min_heap_core #(
	parameter int HEAP_DEPTH   = hmh_pkg::HEAP_DEPTH_DEF,
	parameter int VERTEX_COUNT = hmh_pkg::VERTEX_COUNT_DEF,
	parameter int WEIGHT_BITS  = hmh_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // vertex[9:0], weight[41:10], zero fill
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // out_vertex[9:0], out_weight[41:10],
	                                    // entry_count[52:42], is_empty[53], zero fill
	output logic [2:0]       m_tuser,   // found[0], status[2:1]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);
	import hmh_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [VERTEX_W-1:0] out_vertex;
	logic [WEIGHT_W-1:0] out_weight;
	logic                found;
	status_t             status;
	logic [COUNT_W-1:0]  entry_count;
	logic                is_empty;

	// The capacity register may be written at any time the block is idle.
	assign cfg_ready = 1'b1;

	assign m_tdata = {2'b00, is_empty, entry_count, out_weight, out_vertex};
	assign m_tuser = {status, found};

	hmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	hmh_dp #(
		.HEAP_DEPTH   (HEAP_DEPTH),
		.VERTEX_COUNT (VERTEX_COUNT),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (op_t'(s_tuser[1:0])),
		.vertex      (s_tdata[9:0]),
		.weight      (s_tdata[41:10]),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_vertex  (out_vertex),
		.out_weight  (out_weight),
		.found       (found),
		.status      (status),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	// An accepted transaction occupies the controller until its result is loaded.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while one is in progress");

	// The reported count never exceeds the heap depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[52:42]) <= 32'(HEAP_DEPTH)))
		else $error("entry count beyond heap depth");

	// An extracted entry always comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
		else $error("entry returned with a failing status");

	// The empty flag agrees with the count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[53] == (m_tdata[52:42] == '0)))
		else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

@@ hw/rtl/hmh_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/hmh_dp.sv @@
// ----------------------------------------------------------------------------
// Indexed min-heap datapath
// Heap and position memories, the moving entry, slot arithmetic and the
// result registers, all driven by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module hmh_dp #(
	parameter int HEAP_DEPTH   = hmh_pkg::HEAP_DEPTH_DEF,
	parameter int VERTEX_COUNT = hmh_pkg::VERTEX_COUNT_DEF,
	parameter int WEIGHT_BITS  = hmh_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hmh_pkg::cmd_t                 cmd,
	output hmh_pkg::sts_t                      sts,
	input  wire hmh_pkg::op_t                  operation,
	input  wire logic [hmh_pkg::VERTEX_W-1:0]  vertex,
	input  wire logic [hmh_pkg::WEIGHT_W-1:0]  weight,
	input  wire logic                          cfg_we,
	input  wire logic [hmh_pkg::COUNT_W-1:0]   cfg_data,
	output logic      [hmh_pkg::VERTEX_W-1:0]  out_vertex,
	output logic      [hmh_pkg::WEIGHT_W-1:0]  out_weight,
	output logic                               found,
	output hmh_pkg::status_t                   status,
	output logic      [hmh_pkg::COUNT_W-1:0]   entry_count,
	output logic                               is_empty
);
	import hmh_pkg::*;

	localparam int SW = $clog2(HEAP_DEPTH);
	localparam int VW = $clog2(VERTEX_COUNT);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int XW = CW + 1;
	localparam int EW = VW + WEIGHT_BITS;
	localparam int PW = SW + 1;

	op_t                    op_q;
	logic [VW-1:0]          vtx_q;
	logic                   rng_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [COUNT_W-1:0]     cap_q;
	logic [CW-1:0]          count_q;
	logic [SW-1:0]          idx_q;
	logic [VW-1:0]          mov_v_q;
	logic [WEIGHT_BITS-1:0] mov_w_q;
	logic [VW-1:0]          lft_v_q;
	logic [WEIGHT_BITS-1:0] lft_w_q;
	logic [VW-1:0]          ov_q;
	logic [WEIGHT_BITS-1:0] ow_q;
	logic                   found_q;
	status_t                status_q;
	logic [VW-1:0]          clr_q;

	logic [EW-1:0]          hrd;
	logic [PW-1:0]          prd;
	logic [VW-1:0]          hrd_v;
	logic [WEIGHT_BITS-1:0] hrd_w;
	logic                   prd_valid;
	logic [SW-1:0]          prd_slot;
	logic [SW-1:0]          parent;
	logic [SW-1:0]          last;
	logic [XW-1:0]          left_x;
	logic [XW-1:0]          right_x;
	logic                   has_right;
	logic                   use_l;
	logic                   use_r;
	logic [WEIGHT_BITS-1:0] best_w;

	logic                   h_we;
	logic [SW-1:0]          h_waddr;
	logic [EW-1:0]          h_wdata;
	logic [SW-1:0]          h_raddr;
	logic                   p_we;
	logic [VW-1:0]          p_waddr;
	logic [PW-1:0]          p_wdata;

	assign hrd_v     = hrd[EW-1:WEIGHT_BITS];
	assign hrd_w     = hrd[WEIGHT_BITS-1:0];
	assign prd_valid = prd[SW];
	assign prd_slot  = prd[SW-1:0];
	assign parent    = SW'((idx_q - 1'b1) >> 1);
	assign last      = SW'(count_q - CW'(1));
	assign left_x    = (XW'(idx_q) << 1) + XW'(1);
	assign right_x   = left_x + XW'(1);
	assign has_right = right_x < XW'(count_q);

	// Sift-down choice: left wins ties against the right child.
	assign use_l  = lft_w_q < mov_w_q;
	assign best_w = use_l ? lft_w_q : mov_w_q;
	assign use_r  = has_right && (hrd_w < best_w);

	always_comb begin
		sts.op           = op_q;
		sts.clr_done     = clr_q == VW'(VERTEX_COUNT - 1);
		sts.in_range     = rng_q;
		sts.full         = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= 32'(HEAP_DEPTH));
		sts.pos_valid    = prd_valid;
		sts.dec_ok       = prd_valid && (XW'(prd_slot) < XW'(count_q));
		sts.weight_lower = hrd_w > w_q;
		sts.count_zero   = count_q == '0;
		sts.last_zero    = count_q == CW'(1);
		sts.idx_zero     = idx_q == '0;
		sts.up_swap      = hrd_w > mov_w_q;
		sts.has_left     = left_x < XW'(count_q);
		sts.dn_swap      = use_l || use_r;
	end

	always_comb begin
		case (cmd.hsel)
			HR_POS:    h_raddr = prd_slot;
			HR_LAST:   h_raddr = last;
			HR_PARENT: h_raddr = parent;
			HR_LEFT:   h_raddr = SW'(left_x);
			HR_RIGHT:  h_raddr = SW'(right_x);
			default:   h_raddr = '0;
		endcase
	end

	always_comb begin
		h_we    = cmd.up_move || cmd.dn_move || cmd.place;
		h_waddr = idx_q;
		p_we    = h_we || cmd.clr_wr || cmd.last_cap;
		p_waddr = mov_v_q;
		p_wdata = {1'b1, idx_q};
		h_wdata = {mov_v_q, mov_w_q};
		if (cmd.up_move) begin
			h_wdata = hrd;
			p_waddr = hrd_v;
		end else if (cmd.dn_move) begin
			h_wdata = use_r ? hrd : {lft_v_q, lft_w_q};
			p_waddr = use_r ? hrd_v : lft_v_q;
		end else if (cmd.clr_wr) begin
			p_waddr = clr_q;
			p_wdata = '0;
		end else if (cmd.last_cap) begin
			p_waddr = ov_q;
			p_wdata = '0;
		end
	end

	hmh_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (hrd)
	);

	hmh_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (vtx_q),
		.rdata (prd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.ins_start) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.last_cap) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q     <= operation;
			vtx_q    <= VW'(vertex);
			rng_q    <= 32'(vertex) < 32'(VERTEX_COUNT);
			w_q      <= WEIGHT_BITS'(weight);
			ov_q     <= '0;
			ow_q     <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.ins_start) begin
			idx_q   <= SW'(count_q);
			mov_v_q <= vtx_q;
			mov_w_q <= w_q;
		end
		if (cmd.dec_start) begin
			idx_q   <= prd_slot;
			mov_v_q <= vtx_q;
			mov_w_q <= w_q;
		end
		if (cmd.root_cap) begin
			ov_q    <= hrd_v;
			ow_q    <= hrd_w;
			found_q <= 1'b1;
		end
		if (cmd.last_cap) begin
			mov_v_q <= hrd_v;
			mov_w_q <= hrd_w;
			idx_q   <= '0;
		end
		if (cmd.left_cap) begin
			lft_v_q <= hrd_v;
			lft_w_q <= hrd_w;
		end
		if (cmd.up_move) begin
			idx_q <= parent;
		end
		if (cmd.dn_move) begin
			idx_q <= use_r ? SW'(right_x) : SW'(left_x);
		end
		if (cmd.out_load) begin
			out_vertex  <= VERTEX_W'(ov_q);
			out_weight  <= WEIGHT_W'(ow_q);
			found       <= found_q;
			status      <= status_q;
			entry_count <= COUNT_W'(count_q);
			is_empty    <= count_q == '0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hmh_ctrl.sv @@
// ----------------------------------------------------------------------------
// Indexed min-heap controller
// Sequences the clearing pass and each operation's checks and sift steps,
// and holds the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hmh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hmh_pkg::sts_t  sts,
	output hmh_pkg::cmd_t       cmd,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready
);
	import hmh_pkg::*;

	typedef enum logic [13:0] {
		S_CLEAR    = 14'b00000000000001,
		S_IDLE     = 14'b00000000000010,
		S_DISPATCH = 14'b00000000000100,
		S_PCHK     = 14'b00000000001000,
		S_HCHK     = 14'b00000000010000,
		S_X1       = 14'b00000000100000,
		S_X2       = 14'b00000001000000,
		S_UP_TEST  = 14'b00000010000000,
		S_UP_CMP   = 14'b00000100000000,
		S_DN_TEST  = 14'b00001000000000,
		S_DN_LEFT  = 14'b00010000000000,
		S_DN_CMP   = 14'b00100000000000,
		S_PLACE    = 14'b01000000000000,
		S_DONE     = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.hsel   = HR_ROOT;
		cmd.status = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (sts.op)
					OP_INSERT: begin
						if (!sts.in_range) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_REJECT;
						end else if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							state_d = S_PCHK;
						end
					end
					OP_EXTRACT: begin
						if (sts.count_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							state_d = S_X1;
						end
					end
					OP_DECREASE: begin
						if (!sts.in_range) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_REJECT;
						end else begin
							state_d = S_PCHK;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_PCHK: begin
				state_d = S_DONE;
				if (sts.op == OP_INSERT) begin
					if (sts.pos_valid) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_REJECT;
					end else begin
						cmd.ins_start = 1'b1;
						state_d       = S_UP_TEST;
					end
				end else if (sts.dec_ok) begin
					cmd.dec_start = 1'b1;
					cmd.hsel      = HR_POS;
					state_d       = S_HCHK;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_REJECT;
				end
			end
			S_HCHK: begin
				if (sts.weight_lower) begin
					state_d = S_UP_TEST;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_REJECT;
					state_d        = S_DONE;
				end
			end
			S_X1: begin
				cmd.root_cap = 1'b1;
				cmd.hsel     = HR_LAST;
				state_d      = S_X2;
			end
			S_X2: begin
				cmd.last_cap = 1'b1;
				state_d      = sts.last_zero ? S_DONE : S_DN_TEST;
			end
			S_UP_TEST: begin
				if (sts.idx_zero) begin
					state_d = S_PLACE;
				end else begin
					cmd.hsel = HR_PARENT;
					state_d  = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_swap) begin
					cmd.up_move = 1'b1;
					state_d     = S_UP_TEST;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_TEST: begin
				if (sts.has_left) begin
					cmd.hsel = HR_LEFT;
					state_d  = S_DN_LEFT;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_LEFT: begin
				cmd.left_cap = 1'b1;
				cmd.hsel     = HR_RIGHT;
				state_d      = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_swap) begin
					cmd.dn_move = 1'b1;
					state_d     = S_DN_TEST;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
